// File: sv/lps_pkg.sv
package lps_pkg;

    // field widths
    localparam int SLOT_W = 16;
    localparam int OFF_W  = 20;
    localparam int LEN_W  = 16;
    localparam int SL_W   = 20;
    localparam int TGT_W  = 21;
    localparam int DIST_W = 17;
    localparam int SPAN_W = 37;
    localparam int SUM_W  = 22;
    localparam int CNT_W  = 4;
    localparam int IDX_W  = 2;

    // at most this many segments per period, whatever the parameter says
    localparam int OUT_LIMIT = 8;

    // restoring divider: one quotient bit per step
    localparam int DIV_STEPS = TGT_W;
    localparam int STEP_W    = 5;

    // register indexes on the configuration channel
    localparam logic [IDX_W-1:0] REG_SLOT_LENGTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_LOOP_ENABLE = 2'd1;
    localparam logic [IDX_W-1:0] REG_LOOP_BEGIN  = 2'd2;
    localparam logic [IDX_W-1:0] REG_LOOP_END    = 2'd3;

    localparam logic [SL_W-1:0]   SLOT_LENGTH_RST = 20'd1024;
    localparam logic [SLOT_W-1:0] LOOP_END_RST    = 16'd3;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic jump;
        logic div_start;
        logic div_step;
        logic mul;
        logic left;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic period_zero;
        logic past_end;
        logic finish;
        logic out_free;
    } t_dp_sts;

endpackage

// File: sv/lps_in_if.sv
interface lps_in_if;
    logic                       valid;
    logic                       ready;
    logic [lps_pkg::LEN_W-1:0]  period_frames;

    modport source (output valid, output period_frames, input ready);
    modport sink   (input valid, input period_frames, output ready);
endinterface

// File: sv/lps_out_if.sv
interface lps_out_if;
    logic                       valid;
    logic                       ready;
    logic [lps_pkg::SLOT_W-1:0] seg_timeslot;
    logic [lps_pkg::OFF_W-1:0]  seg_offset;
    logic [lps_pkg::LEN_W-1:0]  seg_length;
    logic                       last;
    logic                       overflow;

    modport source (output valid, output seg_timeslot, output seg_offset, output seg_length,
                    output last, output overflow, input ready);
    modport sink   (input valid, input seg_timeslot, input seg_offset, input seg_length,
                    input last, input overflow, output ready);
endinterface

// File: sv/lps_cfg_if.sv
interface lps_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lps_pkg::IDX_W-1:0]  index;
    logic [lps_pkg::SL_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/lps_ctrl.sv
module lps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lps_pkg::t_dp_sts i_sts,
    output lps_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_LEFT  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    localparam logic [lps_pkg::STEP_W-1:0] STEP_LAST =
        lps_pkg::STEP_W'(lps_pkg::DIV_STEPS - 1);

    logic [2:0]                 r_state, n_state;
    logic [lps_pkg::STEP_W-1:0] r_step, n_step;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.period_zero ? ST_IDLE : ST_CHECK;
                end
            end
            ST_CHECK: begin
                // a playhead beyond the loop jumps back first
                if (i_sts.past_end) begin
                    o_cmd.jump = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_step          = '0;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_LEFT;
            end
            ST_LEFT: begin
                o_cmd.left = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.finish ? ST_IDLE : ST_CHECK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // divider always runs its full length before the span multiply
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_step == STEP_LAST) |=> (r_state == ST_MUL))
        else $error("divider did not hand over to span multiply");

endmodule

// File: sv/lps_datapath.sv
module lps_datapath #(
    parameter int SEG_CAP = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lps_pkg::t_dp_cmd            i_cmd,
    output lps_pkg::t_dp_sts            o_sts,
    input  logic                        i_cfg_valid,
    input  logic [lps_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [lps_pkg::SL_W-1:0]    i_cfg_data,
    input  logic [lps_pkg::LEN_W-1:0]   i_period_frames,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [lps_pkg::SLOT_W-1:0]  o_seg_timeslot,
    output logic [lps_pkg::OFF_W-1:0]   o_seg_offset,
    output logic [lps_pkg::LEN_W-1:0]   o_seg_length,
    output logic                        o_last,
    output logic                        o_overflow
);

    localparam int SLOT_W = lps_pkg::SLOT_W;
    localparam int OFF_W  = lps_pkg::OFF_W;
    localparam int LEN_W  = lps_pkg::LEN_W;
    localparam int SL_W   = lps_pkg::SL_W;
    localparam int TGT_W  = lps_pkg::TGT_W;
    localparam int DIST_W = lps_pkg::DIST_W;
    localparam int SPAN_W = lps_pkg::SPAN_W;
    localparam int SUM_W  = lps_pkg::SUM_W;
    localparam int CNT_W  = lps_pkg::CNT_W;

    localparam logic [CNT_W-1:0] CAP = CNT_W'(SEG_CAP);

    // configuration registers
    logic [SL_W-1:0]   r_slot_length;
    logic              r_loop_enable;
    logic [SLOT_W-1:0] r_loop_begin;
    logic [SLOT_W-1:0] r_loop_end;

    // playhead and per-item state
    logic [SLOT_W-1:0] r_slot;
    logic [OFF_W-1:0]  r_offset;
    logic [LEN_W-1:0]  r_remain;
    logic [CNT_W-1:0]  r_count;
    logic [SL_W-1:0]   r_sl;
    logic              r_looping;

    // divider, span and clip
    logic [TGT_W-1:0]  r_dq;
    logic [SL_W-1:0]   r_drem;
    logic [SPAN_W-1:0] r_span;
    logic [LEN_W-1:0]  r_left;
    logic              r_inside;

    // output register
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic [OFF_W-1:0]  r_out_off;
    logic [LEN_W-1:0]  r_out_len;
    logic              r_out_last;
    logic              r_out_ovf;

    logic [TGT_W-1:0]  w_rem_sh;
    logic [TGT_W-1:0]  w_sub;
    logic              w_ge;
    logic [DIST_W-1:0] w_dist;
    logic [SPAN_W-1:0] w_span;
    logic [SPAN_W-1:0] w_room;
    logic [SUM_W-1:0]  w_slot_sum;
    logic [LEN_W-1:0]  w_rem_after;
    logic              w_cap_hit;
    logic              w_last_wrap;
    logic              w_out_free;
    logic              w_emit_seg;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_length <= lps_pkg::SLOT_LENGTH_RST;
            r_loop_enable <= 1'b1;
            r_loop_begin  <= '0;
            r_loop_end    <= lps_pkg::LOOP_END_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lps_pkg::REG_SLOT_LENGTH: r_slot_length <= i_cfg_data;
                lps_pkg::REG_LOOP_ENABLE: r_loop_enable <= i_cfg_data[0];
                lps_pkg::REG_LOOP_BEGIN:  r_loop_begin  <= i_cfg_data[SLOT_W-1:0];
                lps_pkg::REG_LOOP_END:    r_loop_end    <= i_cfg_data[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    // one restoring division step
    assign w_rem_sh = {r_drem, r_dq[TGT_W-1]};
    assign w_ge     = w_rem_sh >= TGT_W'(r_sl);
    assign w_sub    = w_rem_sh - TGT_W'(r_sl);

    // timeslots from the playhead to the end of the loop, then the frames left in it
    assign w_dist = DIST_W'(r_loop_end) + DIST_W'(1) - DIST_W'(r_slot);
    assign w_span = SPAN_W'(w_dist) * SPAN_W'(r_sl);
    assign w_room = r_span - SPAN_W'(r_offset);

    assign w_slot_sum = SUM_W'(r_slot) + SUM_W'(r_dq);

    // wrap segment bookkeeping
    assign w_rem_after = r_remain - r_left;
    assign w_cap_hit   = (r_count + 1'b1) == CAP;
    assign w_last_wrap = (w_rem_after == '0) || w_cap_hit;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit_seg = i_cmd.emit && (r_inside || r_left != '0);

    // playhead, item and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_offset <= '0;
            r_count  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_sl      <= (r_slot_length == '0) ? SL_W'(1) : r_slot_length;
                r_looping <= r_loop_enable && (r_loop_begin <= r_loop_end);
                r_remain  <= i_period_frames;
                r_count   <= '0;
            end
            if (i_cmd.jump) begin
                r_slot   <= r_loop_begin;
                r_offset <= '0;
            end
            if (i_cmd.div_start) begin
                r_dq   <= TGT_W'(r_offset) + TGT_W'(r_remain);
                r_drem <= '0;
            end
            if (i_cmd.div_step) begin
                r_dq   <= {r_dq[TGT_W-2:0], w_ge};
                r_drem <= w_ge ? w_sub[SL_W-1:0] : w_rem_sh[SL_W-1:0];
            end
            if (i_cmd.mul) begin
                r_span <= w_span;
            end
            if (i_cmd.left) begin
                // rest of the loop, clipped to the frames still to place
                if (r_span <= SPAN_W'(r_offset)) begin
                    r_left <= '0;
                end else if (w_room > SPAN_W'(r_remain)) begin
                    r_left <= r_remain;
                end else begin
                    r_left <= w_room[LEN_W-1:0];
                end
                r_inside <= (r_dq == '0) || !r_looping
                            || (w_slot_sum <= SUM_W'(r_loop_end));
            end
            if (i_cmd.emit) begin
                if (r_inside) begin
                    r_slot   <= r_slot + r_dq[SLOT_W-1:0];
                    r_offset <= r_drem;
                    r_remain <= '0;
                    r_count  <= r_count + 1'b1;
                end else begin
                    if (r_left != '0) begin
                        r_remain <= w_rem_after;
                        r_count  <= r_count + 1'b1;
                    end
                    r_slot   <= r_loop_begin;
                    r_offset <= '0;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_seg) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_seg) begin
            r_out_slot <= r_slot;
            r_out_off  <= r_offset;
            if (r_inside) begin
                r_out_len  <= r_remain;
                r_out_last <= 1'b1;
                r_out_ovf  <= 1'b0;
            end else begin
                r_out_len  <= r_left;
                r_out_last <= w_last_wrap;
                r_out_ovf  <= (w_rem_after != '0) && w_cap_hit;
            end
        end
    end

    // status
    assign o_sts.period_zero = (i_period_frames == '0);
    assign o_sts.past_end    = r_looping && (r_slot > r_loop_end);
    assign o_sts.finish      = r_inside || ((r_left != '0) && w_last_wrap);
    assign o_sts.out_free    = w_out_free;

    assign o_out_valid    = r_out_valid;
    assign o_seg_timeslot = r_out_slot;
    assign o_seg_offset   = r_out_off;
    assign o_seg_length   = r_out_len;
    assign o_last         = r_out_last;
    assign o_overflow     = r_out_ovf;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("segment count beyond cap");

    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> r_out_last)
        else $error("overflow on a segment that is not last");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_len != '0))
        else $error("zero-length segment emitted");

endmodule

// File: sv/loop_playhead_segmenter.sv
// Channel  Dir  Payload                                              Handshake
// i_period in   period_frames                                        valid/ready
// i_cfg    in   index (0 slot_length, 1 loop_enable, 2..3 loop span)  valid/ready
// o_seg    out  seg_timeslot seg_offset seg_length last overflow      valid/ready
//
// After the accept, each segment takes a check, 21 divider steps (one quotient
// bit a cycle), the span multiply, the clip and emit. A playhead past the loop
// end first jumps back to the loop start; a wrap with no loop left runs the steps
// but gives no segment; a zero-frame period gives none. Up to 8 per period.
// Reset is synchronous, active low; config writes are always taken.
// A stalled o_seg holds the emit step until the output register frees.
module loop_playhead_segmenter #(
    parameter int MAX_SEGMENTS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lps_in_if.sink        i_period,
    lps_cfg_if.sink       i_cfg,
    lps_out_if.source     o_seg
);

    localparam int SEG_CAP = (MAX_SEGMENTS < lps_pkg::OUT_LIMIT) ?
                             MAX_SEGMENTS : lps_pkg::OUT_LIMIT;

    lps_pkg::t_dp_cmd w_cmd;
    lps_pkg::t_dp_sts w_sts;
    logic             w_in_ready;

    // configuration registers never stall
    assign i_cfg.ready    = 1'b1;
    assign i_period.ready = w_in_ready;

    lps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_period.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lps_datapath #(
        .SEG_CAP (SEG_CAP)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_period_frames (i_period.period_frames),
        .i_out_ready     (o_seg.ready),
        .o_out_valid     (o_seg.valid),
        .o_seg_timeslot  (o_seg.seg_timeslot),
        .o_seg_offset    (o_seg.seg_offset),
        .o_seg_length    (o_seg.seg_length),
        .o_last          (o_seg.last),
        .o_overflow      (o_seg.overflow)
    );

endmodule
